// ===== hw/rtl/dhp_pkg.sv =====
// ----------------------------------------------------------------------------
// dhp_pkg
// shared types and constants for the density histogram block
// ----------------------------------------------------------------------------
package dhp_pkg;
  localparam int unsigned DEF_MAX_SAMPLES = 1024;
  localparam int unsigned DEF_MAX_BINS    = 64;
  localparam int unsigned SAMPLE_W        = 32;
  localparam int unsigned BINCFG_W        = 7;
  localparam int unsigned BINIDX_W        = 6;
  localparam int unsigned DENS_W          = 32;
  localparam logic [BINCFG_W-1:0] BIN_COUNT_RST = 7'd30;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last_sample;
  } in_item_t;

  typedef struct packed {
    logic [BINIDX_W-1:0] bin_index;
    logic [DENS_W-1:0]   density;
    logic [BINIDX_W-1:0] peak_bin;
    logic                exponential_guess;
    logic                last_bin;
  } out_item_t;
endpackage

// ===== hw/rtl/dhp_if.sv =====
// ----------------------------------------------------------------------------
// dhp_in_if / dhp_out_if
// valid/ready channels for samples and bin results
// ----------------------------------------------------------------------------
interface dhp_in_if;
  logic                 valid;
  logic                 ready;
  logic signed [31:0]   sample;
  logic                 last_sample;
  modport source (output valid, sample, last_sample, input ready);
  modport sink   (input valid, sample, last_sample, output ready);
endinterface

interface dhp_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  bin_index;
  logic [31:0] density;
  logic [5:0]  peak_bin;
  logic        exponential_guess;
  logic        last_bin;
  modport source (output valid, bin_index, density, peak_bin, exponential_guess, last_bin,
                  input ready);
  modport sink   (input valid, bin_index, density, peak_bin, exponential_guess, last_bin,
                  output ready);
endinterface

// ===== hw/rtl/density_histogram_with_peak.sv =====
// divider: binning and density passes share one bit-serial divider, at most one
// division per sample and per bin
// throughput: one sample per cycle while loading; loading stalls from a set's last
// transaction until that set is binned
// results: B transactions per set, one per cycle when the sink is ready
// reset: synchronous active-low clears control, counts, min/max; bin_count to 30
// ----------------------------------------------------------------------------
// density_histogram_with_peak
// histogram density of a sample set with peak bin and shape guess
// ----------------------------------------------------------------------------
module density_histogram_with_peak import dhp_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int unsigned MAX_BINS    = DEF_MAX_BINS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [BINCFG_W-1:0] cfg_wdata,
  dhp_in_if.sink              in_ch,
  dhp_out_if.source           out_ch
);
  localparam int unsigned AW = $clog2(MAX_SAMPLES);
  logic [BINCFG_W-1:0]  bin_count_r;
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [SAMPLE_W-1:0]  wdata, rdata;
  logic                 q_valid, q_ready;
  logic [$clog2(MAX_SAMPLES+1)-1:0] q_n;
  logic signed [SAMPLE_W-1:0] q_min, q_max;

  always_ff @(posedge clk) begin
    if (!rst_n) bin_count_r <= BIN_COUNT_RST;
    else if (cfg_we) bin_count_r <= cfg_wdata;
  end

  dhp_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk, .rst_n, .in_ch, .we, .waddr, .wdata,
    .q_valid, .q_ready, .q_n, .q_min, .q_max
  );

  dhp_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_store (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  dhp_back #(.MAX_SAMPLES(MAX_SAMPLES), .MAX_BINS(MAX_BINS)) u_back (
    .clk, .rst_n, .bin_count(bin_count_r), .q_valid, .q_ready, .q_n, .q_min, .q_max,
    .raddr, .rdata, .out_ch
  );
endmodule

// ===== hw/rtl/dhp_ram.sv =====
// ----------------------------------------------------------------------------
// dhp_ram
// generic single-port write, single-port read ram with registered read
// ----------------------------------------------------------------------------
module dhp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/dhp_div.sv =====
// ----------------------------------------------------------------------------
// dhp_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module dhp_div #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 48
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int unsigned CW = $clog2(NW + 1);
  logic [NW-1:0] q_r;
  logic [DW:0]   rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW:0]   sh;
  logic [DW:0]   diff;

  assign sh   = {rem_r[DW-1:0], q_r[NW-1]};
  assign diff = sh - {1'b0, den_r};
  assign quo  = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
        q_r    <= num;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        if (!diff[DW]) begin
          rem_r <= diff;
          q_r   <= {q_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= sh;
          q_r   <= {q_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== hw/rtl/dhp_front.sv =====
// ----------------------------------------------------------------------------
// dhp_front
// accepts samples, stores them, tracks min and max, queues set-close events
// ----------------------------------------------------------------------------
module dhp_front import dhp_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  dhp_in_if.sink                         in_ch,
  output logic                           we,
  output logic [$clog2(MAX_SAMPLES)-1:0] waddr,
  output logic [SAMPLE_W-1:0]            wdata,
  output logic                           q_valid,
  input  logic                           q_ready,
  output logic [$clog2(MAX_SAMPLES+1)-1:0] q_n,
  output logic signed [SAMPLE_W-1:0]     q_min,
  output logic signed [SAMPLE_W-1:0]     q_max
);
  localparam int unsigned NW = $clog2(MAX_SAMPLES + 1);
  logic [NW-1:0]              cnt_r;
  logic signed [SAMPLE_W-1:0] min_r, max_r;
  logic                       qv_r;
  logic                       acc, store;
  logic signed [SAMPLE_W-1:0] mn_nxt, mx_nxt;

  // one-entry queue between front and back; a pending close stalls input
  assign in_ch.ready = !qv_r;
  assign acc   = in_ch.valid && in_ch.ready;
  assign store = acc && (cnt_r < NW'(MAX_SAMPLES));
  assign we    = store;
  assign waddr = cnt_r[$clog2(MAX_SAMPLES)-1:0];
  assign wdata = in_ch.sample;
  assign mn_nxt = (store && in_ch.sample < min_r) ? in_ch.sample : min_r;
  assign mx_nxt = (store && in_ch.sample > max_r) ? in_ch.sample : max_r;
  assign q_valid = qv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      min_r <= 32'sh7FFFFFFF;
      max_r <= 32'sh80000000;
      qv_r  <= 1'b0;
    end else begin
      if (qv_r && q_ready) qv_r <= 1'b0;
      if (acc && in_ch.last_sample) begin
        qv_r  <= 1'b1;
        q_n   <= store ? cnt_r + 1'b1 : cnt_r;
        q_min <= mn_nxt;
        q_max <= mx_nxt;
        cnt_r <= '0;
        min_r <= 32'sh7FFFFFFF;
        max_r <= 32'sh80000000;
      end else begin
        if (store) cnt_r <= cnt_r + 1'b1;
        min_r <= mn_nxt;
        max_r <= mx_nxt;
      end
    end
  end
endmodule

// ===== hw/rtl/dhp_back.sv =====
// ----------------------------------------------------------------------------
// dhp_back
// bins the stored set, computes densities and peak, emits one result per bin
// ----------------------------------------------------------------------------
module dhp_back import dhp_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int unsigned MAX_BINS    = DEF_MAX_BINS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [BINCFG_W-1:0]              bin_count,
  input  logic                             q_valid,
  output logic                             q_ready,
  input  logic [$clog2(MAX_SAMPLES+1)-1:0] q_n,
  input  logic signed [SAMPLE_W-1:0]       q_min,
  input  logic signed [SAMPLE_W-1:0]       q_max,
  output logic [$clog2(MAX_SAMPLES)-1:0]   raddr,
  input  logic [SAMPLE_W-1:0]              rdata,
  dhp_out_if.source                        out_ch
);
  localparam int unsigned NW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AW = $clog2(MAX_SAMPLES);
  localparam int unsigned BW = $clog2(MAX_BINS);
  localparam int unsigned BCW = $clog2(MAX_BINS + 1);
  localparam int unsigned RW = SAMPLE_W + 1;
  localparam int unsigned DNW = RW + NW;          // n * range
  localparam int unsigned QW = 64;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_BINW  = 4'd5;
  localparam logic [3:0] S_DPREP = 4'd6;
  localparam logic [3:0] S_DDIV  = 4'd7;
  localparam logic [3:0] S_DWAIT = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;
  localparam logic [3:0] S_BINR  = 4'd10;
  localparam logic [3:0] S_DRD   = 4'd11;
  localparam logic [3:0] S_ERD   = 4'd12;

  logic [3:0]           st_r;
  logic [BCW-1:0]       b_r;
  logic [NW-1:0]        n_r, k_r;
  logic [RW-1:0]        range_r;
  logic signed [SAMPLE_W-1:0] min_r;
  logic [BW-1:0]        i_r, peak_r;
  logic [DENS_W-1:0]    best_r;
  logic [DENS_W-1:0]    dv_r;
  logic [RW+BCW-1:0]    prod_r;
  logic [BW-1:0]        bin_r;
  logic                 started_r;
  logic                 ov_r;
  out_item_t            o_r;

  logic                 dstart, ddone;
  logic [QW-1:0]        dnum, dquo;
  logic [DNW-1:0]       dden;
  logic [BCW-1:0]       b_use;
  logic [RW-1:0]        d_s;
  logic [DENS_W-1:0]    v_sat;
  logic [BW-1:0]        lastb;
  logic                 slot_free;
  logic [NW+BCW-1:0]    cb;

  logic                 c_we;
  logic [BW-1:0]        c_waddr, c_raddr;
  logic [NW-1:0]        c_wdata, c_rdata;
  logic                 dn_we;
  logic [BW-1:0]        dn_waddr, dn_raddr;
  logic [DENS_W-1:0]    dn_wdata, dn_rdata;

  dhp_div #(.NW(QW), .DW(DNW)) u_div (
    .clk, .rst_n, .start(dstart), .num(dnum), .den(dden), .done(ddone), .quo(dquo)
  );

  dhp_ram #(.WIDTH(NW), .DEPTH(MAX_BINS)) u_cnt (
    .clk, .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr), .rdata(c_rdata)
  );

  dhp_ram #(.WIDTH(DENS_W), .DEPTH(MAX_BINS)) u_dens (
    .clk, .we(dn_we), .waddr(dn_waddr), .wdata(dn_wdata), .raddr(dn_raddr),
    .rdata(dn_rdata)
  );

  always_comb begin
    if (bin_count == '0) b_use = BCW'(1);
    else if (bin_count > BINCFG_W'(MAX_BINS)) b_use = BCW'(MAX_BINS);
    else b_use = BCW'(bin_count);
  end

  // the stored set is released once every sample has been binned
  assign q_ready = (st_r == S_BINW && k_r + 1'b1 == n_r) ||
                   (st_r == S_CLR && i_r == BW'(MAX_BINS - 1) && n_r == '0);
  assign raddr   = k_r[AW-1:0];
  assign lastb   = BW'(b_r - 1'b1);
  assign d_s     = RW'(signed'({rdata[SAMPLE_W-1], rdata}) - signed'({min_r[SAMPLE_W-1], min_r}));
  assign v_sat   = (dquo[QW-1:DENS_W] != '0) ? '1 : dquo[DENS_W-1:0];
  assign slot_free = !ov_r || out_ch.ready;
  assign cb      = (NW+BCW)'(c_rdata) * (NW+BCW)'(b_r);

  assign c_raddr = (st_r == S_BINR) ? bin_r : i_r;
  assign c_we    = (st_r == S_CLR) || (st_r == S_BINW);
  assign c_waddr = (st_r == S_CLR) ? i_r : bin_r;
  assign c_wdata = (st_r == S_CLR) ? '0 : c_rdata + 1'b1;

  assign dn_we    = (st_r == S_DPREP && (c_rdata == '0 || n_r == '0 || range_r == '0)) ||
                    (st_r == S_DDIV && ddone);
  assign dn_waddr = i_r;
  assign dn_wdata = (st_r == S_DDIV) ? v_sat : ((c_rdata == '0 || n_r == '0) ? '0 : '1);
  assign dn_raddr = (st_r == S_EMIT && slot_free) ? i_r + 1'b1 : i_r;

  always_comb begin
    dstart = 1'b0;
    dnum   = '0;
    dden   = '0;
    if (st_r == S_MUL && started_r) begin
      dstart = 1'b1;
      dnum   = QW'(prod_r);
      dden   = DNW'(range_r);
    end else if (st_r == S_DPREP) begin
      dstart = (c_rdata != '0) && (range_r != '0);
      dnum   = QW'(cb) << 32;
      dden   = DNW'(n_r) * DNW'(range_r);
    end
  end

  assign out_ch.valid             = ov_r;
  assign out_ch.bin_index         = o_r.bin_index;
  assign out_ch.density           = o_r.density;
  assign out_ch.peak_bin          = o_r.peak_bin;
  assign out_ch.exponential_guess = o_r.exponential_guess;
  assign out_ch.last_bin          = o_r.last_bin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      ov_r      <= 1'b0;
      started_r <= 1'b0;
    end else begin
      if (ov_r && out_ch.ready) ov_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          b_r     <= b_use;
          n_r     <= q_n;
          min_r   <= q_min;
          range_r <= RW'(signed'({q_max[SAMPLE_W-1], q_max}) -
                         signed'({q_min[SAMPLE_W-1], q_min}));
          i_r     <= '0;
          k_r     <= '0;
          st_r    <= S_CLR;
        end
        S_CLR: begin
          i_r <= i_r + 1'b1;
          if (i_r == BW'(MAX_BINS - 1)) st_r <= (n_r == '0) ? S_DRD : S_RD;
        end
        S_RD: begin
          // read issued, data valid next cycle
          started_r <= 1'b0;
          st_r <= S_MUL;
        end
        S_MUL: begin
          if (!started_r) begin
            prod_r    <= (RW+BCW)'(d_s) * (RW+BCW)'(b_r);
            started_r <= 1'b1;
            if (range_r == '0) begin
              bin_r <= lastb;
              st_r  <= S_BINR;
            end
          end else begin
            st_r <= S_DIV;
          end
        end
        S_DIV: if (ddone) begin
          bin_r <= (dquo >= QW'(b_r)) ? lastb : dquo[BW-1:0];
          st_r  <= S_BINR;
        end
        S_BINR: st_r <= S_BINW;
        S_BINW: begin
          k_r <= k_r + 1'b1;
          if (k_r + 1'b1 == n_r) begin
            i_r    <= '0;
            best_r <= '0;
            peak_r <= '0;
            st_r   <= S_DRD;
          end else st_r <= S_RD;
        end
        S_DRD: st_r <= S_DPREP;
        S_DPREP: begin
          if (c_rdata == '0 || n_r == '0) begin
            dv_r <= '0;
            st_r <= S_DWAIT;
          end else if (range_r == '0) begin
            dv_r <= '1;
            st_r <= S_DWAIT;
          end else st_r <= S_DDIV;
        end
        S_DDIV: if (ddone) begin
          dv_r <= v_sat;
          st_r <= S_DWAIT;
        end
        S_DWAIT: begin
          if (i_r == '0 || dv_r > best_r) begin
            best_r <= dv_r;
            peak_r <= i_r;
          end
          if (i_r == lastb) begin
            i_r  <= '0;
            st_r <= S_ERD;
          end else begin
            i_r  <= i_r + 1'b1;
            st_r <= S_DRD;
          end
        end
        S_ERD: st_r <= S_EMIT;
        S_EMIT: if (slot_free) begin
          ov_r <= 1'b1;
          o_r.bin_index <= BINIDX_W'(i_r);
          o_r.density   <= dn_rdata;
          o_r.peak_bin  <= BINIDX_W'(peak_r);
          o_r.exponential_guess <= (peak_r <= BW'(2)) ||
                                   ({1'b0, peak_r} + (BW+1)'(3) >= (BW+1)'(b_r));
          o_r.last_bin  <= (i_r == lastb);
          i_r <= i_r + 1'b1;
          if (i_r == lastb) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/dhp_checker.sv =====
// ----------------------------------------------------------------------------
// dhp_checker
// port-level checks on the result channel
// ----------------------------------------------------------------------------
module dhp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_bin_index,
  input logic [5:0] out_peak_bin,
  input logic       out_last_bin
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bin_index))
    else $error("result dropped while stalled");
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_bin |=> !out_valid || out_bin_index == 6'd0)
    else $error("run does not restart at bin 0");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_bin ##1 out_valid |->
      out_bin_index == $past(out_bin_index) + 6'd1 && out_peak_bin == $past(out_peak_bin))
    else $error("bin order or peak changed within run");
endmodule

bind density_histogram_with_peak dhp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_bin_index(out_ch.bin_index), .out_peak_bin(out_ch.peak_bin),
  .out_last_bin(out_ch.last_bin)
);
